>>> sv/htfc_pkg.sv
`default_nettype none

package htfc_pkg;

    // byte stream and crc
    localparam int           BYTE_W   = 8;
    localparam logic [7:0]   CRC_INIT = 8'hFF;
    localparam logic [7:0]   CRC_POLY = 8'h31;
    localparam logic [2:0]   POS_LAST = 3'd5;

    // scaling and division
    localparam int           SPAN_W    = 15;
    localparam int           WORD_W    = 16;
    localparam int           PROD_W    = SPAN_W + WORD_W;
    localparam int           DIV_STEPS = PROD_W;
    localparam int           CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [SPAN_W-1:0] QUOT_MAX = 15'd30000;
    localparam int           TEMP_W    = 17;

    // result transfer: 65 bits of fields padded to whole bytes
    localparam int           OUT_FIELD_W = TEMP_W + SPAN_W + 2 * WORD_W + 1;
    localparam int           OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int           OUT_PAD_W   = OUT_W - OUT_FIELD_W;

    // register file
    localparam int           APB_AW = 5;
    localparam int           APB_DW = 32;
    localparam logic [2:0]   REG_TEMP_OFFSET  = 3'd0;
    localparam logic [2:0]   REG_TEMP_SPAN    = 3'd1;
    localparam logic [2:0]   REG_TEMP_DIVISOR = 3'd2;
    localparam logic [2:0]   REG_HUM_SPAN     = 3'd3;
    localparam logic [2:0]   REG_HUM_DIVISOR  = 3'd4;

    localparam logic signed [15:0] RST_TEMP_OFFSET  = -16'sd4500;
    localparam logic [14:0]        RST_TEMP_SPAN    = 15'd17500;
    localparam logic [15:0]        RST_TEMP_DIVISOR = 16'd65535;
    localparam logic [14:0]        RST_HUM_SPAN     = 15'd10000;
    localparam logic [15:0]        RST_HUM_DIVISOR  = 16'd65535;

    typedef struct packed {
        logic signed [15:0] temp_offset;
        logic [14:0]        temp_span;
        logic [15:0]        temp_divisor;
        logic [14:0]        hum_span;
        logic [15:0]        hum_divisor;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_BYTE,
        ST_LOAD_T,
        ST_DIV_T,
        ST_LOAD_H,
        ST_DIV_H,
        ST_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic byte_take;
        logic mul_load;
        logic sel_hum;
        logic div_step;
        logic store_temp;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_byte;
        logic out_free;
    } dp_status_t;

    // one byte through the crc, msb first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // clamp a quotient, a zero divisor saturates
    function automatic logic [SPAN_W-1:0] sat_quot(input logic [PROD_W-1:0] q,
                                                   input logic div_zero);
        logic [SPAN_W-1:0] r;
        if (div_zero || q > PROD_W'(QUOT_MAX))
            r = QUOT_MAX;
        else
            r = q[SPAN_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/htfc_ctrl.sv
`default_nettype none

module htfc_ctrl
    import htfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    fsm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BYTE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_BYTE:
            begin
                s_tready      = 1'b1;
                cmd.byte_take = s_tvalid;
                if (s_tvalid && status.last_byte)
                    state_next = ST_LOAD_T;
            end
            ST_LOAD_T:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_T;
            end
            ST_DIV_T:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_LOAD_H;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_LOAD_H:
            begin
                cmd.store_temp = 1'b1;
                cmd.mul_load   = 1'b1;
                cmd.sel_hum    = 1'b1;
                cnt_next       = '0;
                state_next     = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                cmd.div_step = 1'b1;
                cmd.sel_hum  = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_BYTE;
                end
            end
            default:
            begin
                state_next = ST_BYTE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/htfc_dp.sv
`default_nettype none

module htfc_dp
    import htfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              frame_start,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [OUT_W-1:0]       m_tdata
);

    logic [2:0]        pos_reg, pos_next;
    logic [7:0]        crc_reg, crc_next;
    logic [WORD_W-1:0] temp_word_reg, temp_word_next;
    logic [WORD_W-1:0] hum_word_reg, hum_word_next;
    logic              temp_good_reg, temp_good_next;
    logic              hum_good_reg, hum_good_next;
    logic [2:0]        eff_pos;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [SPAN_W-1:0] tq_reg, tq_next;
    logic [WORD_W-1:0] divisor;
    logic [SPAN_W-1:0] span;
    logic [WORD_W-1:0] raw;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;
    logic [SPAN_W-1:0] hq;
    logic [TEMP_W-1:0] temp_sum;

    // position of the incoming byte, a start mark restarts the response
    assign eff_pos = (frame_start || pos_reg > POS_LAST) ? 3'd0 : pos_reg;

    // byte assembly and crc check
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_good_next = temp_good_reg;
        hum_good_next  = hum_good_reg;
        if (cmd.byte_take)
        begin
            pos_next = eff_pos + 3'd1;
            unique case (eff_pos)
                3'd0:
                begin
                    crc_next       = crc_feed(CRC_INIT, rx_byte);
                    temp_word_next = {rx_byte, temp_word_reg[7:0]};
                end
                3'd1:
                begin
                    crc_next       = crc_feed(crc_reg, rx_byte);
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                end
                3'd2:
                begin
                    temp_good_next = (crc_reg == rx_byte);
                    crc_next       = CRC_INIT;
                end
                3'd3:
                begin
                    crc_next      = crc_feed(CRC_INIT, rx_byte);
                    hum_word_next = {rx_byte, hum_word_reg[7:0]};
                end
                3'd4:
                begin
                    crc_next      = crc_feed(crc_reg, rx_byte);
                    hum_word_next = {hum_word_reg[15:8], rx_byte};
                end
                default:
                begin
                    hum_good_next = (crc_reg == rx_byte);
                    crc_next      = CRC_INIT;
                    pos_next      = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            temp_good_reg <= 1'b0;
            hum_good_reg  <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            temp_good_reg <= temp_good_next;
            hum_good_reg  <= hum_good_next;
        end
    end

    // operand selection for the shared multiplier and divider
    assign divisor = cmd.sel_hum ? cfg.hum_divisor : cfg.temp_divisor;
    assign span    = cmd.sel_hum ? cfg.hum_span : cfg.temp_span;
    assign raw     = cmd.sel_hum ? hum_word_reg : temp_word_reg;

    // restoring division, one quotient bit per step shifted into the product
    assign shifted = {rem_reg, prod_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        tq_next   = tq_reg;
        if (cmd.store_temp)
            tq_next = sat_quot(prod_reg, cfg.temp_divisor == '0);
        if (cmd.mul_load)
        begin
            prod_next = PROD_W'(span) * PROD_W'(raw);
            rem_next  = '0;
        end
        else if (cmd.div_step)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next  = diff[WORD_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[WORD_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        tq_reg   <= tq_next;
    end

    // result assembly
    assign hq       = sat_quot(prod_reg, cfg.hum_divisor == '0);
    assign temp_sum = {cfg.temp_offset[15], cfg.temp_offset} + {2'b00, tq_reg};

    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (cmd.load_out)
        begin
            m_data_next  = {{OUT_PAD_W{1'b0}}, temp_good_reg & hum_good_reg,
                            hum_word_reg, temp_word_reg, hq, temp_sum};
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid         = m_valid_reg;
    assign m_tdata          = m_data_reg;
    assign status.last_byte = (eff_pos == POS_LAST);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

>>> sv/humidity_temp_frame_checker.sv
// channel   dir  fields (lowest bit up)
// s_*       in   tdata: rx_byte[7:0]; tuser: frame_start
// m_*       out  tdata: temperature_centi[16:0], humidity_centi[31:17], temp_raw[47:32],
//                hum_raw[63:48], crc_ok[64], zero[71:65]
// apb       in   regs at 4*i: temp_offset, temp_span, temp_divisor, hum_span, hum_divisor
//
// bytes one to five of a response are accepted with s_tready held high
// after the sixth byte, each word gets one multiply and 31 divider steps,
// both words share the one restoring divider, the result loads when the output is free
// a waiting result does not block the next response until the following one is done
// m_tvalid low and crc state 0xff after reset, registers at their reset values
`default_nettype none

module humidity_temp_frame_checker
    import htfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,  // rx_byte
    input  wire logic              s_tuser,  // frame_start
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,  // temperature_centi, humidity_centi,
                                             // temp_raw, hum_raw, crc_ok, zero pad
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    cfg_t       cfg_reg, cfg_next;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TEMP_OFFSET:  cfg_next.temp_offset  = pwdata[15:0];
                REG_TEMP_SPAN:    cfg_next.temp_span    = pwdata[14:0];
                REG_TEMP_DIVISOR: cfg_next.temp_divisor = pwdata[15:0];
                REG_HUM_SPAN:     cfg_next.hum_span     = pwdata[14:0];
                REG_HUM_DIVISOR:  cfg_next.hum_divisor  = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_offset  <= RST_TEMP_OFFSET;
            cfg_reg.temp_span    <= RST_TEMP_SPAN;
            cfg_reg.temp_divisor <= RST_TEMP_DIVISOR;
            cfg_reg.hum_span     <= RST_HUM_SPAN;
            cfg_reg.hum_divisor  <= RST_HUM_DIVISOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            REG_TEMP_OFFSET:  prdata = {{(APB_DW-16){cfg_reg.temp_offset[15]}},
                                        cfg_reg.temp_offset};
            REG_TEMP_SPAN:    prdata = {{(APB_DW-15){1'b0}}, cfg_reg.temp_span};
            REG_TEMP_DIVISOR: prdata = {{(APB_DW-16){1'b0}}, cfg_reg.temp_divisor};
            REG_HUM_SPAN:     prdata = {{(APB_DW-15){1'b0}}, cfg_reg.hum_span};
            REG_HUM_DIVISOR:  prdata = {{(APB_DW-16){1'b0}}, cfg_reg.hum_divisor};
            default:          prdata = '0;
        endcase
    end

    htfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htfc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status      (status),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

>>> sv/htfc_checker.sv
`default_nettype none

module htfc_checker
    import htfc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata
);

    // a result waiting for transfer keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pad bits above the crc flag stay clear
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:OUT_FIELD_W] == '0)
        else $error("result pad bits set");

    // humidity is saturated
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TEMP_W+SPAN_W-1:TEMP_W] <= QUOT_MAX)
        else $error("humidity above saturation limit");

    // a new result only follows a busy cycle of the block, with s_tready low
    a_new_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a calculation");

endmodule

bind humidity_temp_frame_checker htfc_checker u_htfc_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench
    import htfc_pkg::*;
();

    // one result transfer, laid out as on m_tdata (lowest field last)
    typedef struct packed {
        logic [OUT_PAD_W-1:0]   pad;
        logic                   crc_ok;
        logic [WORD_W-1:0]      hum_raw;
        logic [WORD_W-1:0]      temp_raw;
        logic [SPAN_W-1:0]      humidity;
        logic signed [TEMP_W-1:0] temperature;
    } frame_res_t;

    // one row of the directed table
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              start;
        logic              typed;
        frame_res_t        want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;   // rx_byte
    logic              s_tuser = 1'b0; // frame_start
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // temperature_centi, humidity_centi,
                                       // temp_raw, hum_raw, crc_ok, zero pad
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    humidity_temp_frame_checker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

    // shadow of the register file
    logic signed [15:0] cfg_offset = RST_TEMP_OFFSET;
    logic [14:0]        cfg_tspan  = RST_TEMP_SPAN;
    logic [15:0]        cfg_tdiv   = RST_TEMP_DIVISOR;
    logic [14:0]        cfg_hspan  = RST_HUM_SPAN;
    logic [15:0]        cfg_hdiv   = RST_HUM_DIVISOR;

    // frame decoder state
    logic [2:0]         dec_pos = 3'd0;
    logic [7:0]         dec_crc = 8'hFF;
    logic [15:0]        dec_tword = '0;
    logic [15:0]        dec_hword = '0;
    logic               dec_tgood = 1'b0;

    frame_res_t pending_frames[$];
    int         mismatch_cnt = 0;
    int         send_idle = 35;
    int         recv_idle = 62;

    // crc-8, poly 0x31, one byte msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
            c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(8'hFF, w[15:8]), w[7:0]);
    endfunction

    // truncated quotient, saturating at 30000 and on a zero divisor
    function automatic logic [14:0] scaled(input logic [14:0] span, input logic [15:0] raw,
                                           input logic [15:0] div);
        longint unsigned q;
        if (div == 16'd0)
            return 15'd30000;
        q = (longint'(span) * longint'(raw)) / longint'(div);
        return (q > 30000) ? 15'd30000 : q[14:0];
    endfunction

    // advance the frame decoder by one byte, returns 1 with a finished frame
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output frame_res_t r);
        int t;
        r = '0;
        if (st)
        begin
            dec_pos = 3'd0;
            dec_crc = 8'hFF;
        end
        if (dec_pos > 3'd5)
            dec_pos = 3'd0;
        case (dec_pos)
            3'd0:
            begin
                dec_crc = crc8_step(8'hFF, b);
                dec_tword[15:8] = b;
            end
            3'd1:
            begin
                dec_crc = crc8_step(dec_crc, b);
                dec_tword[7:0] = b;
            end
            3'd2:
            begin
                dec_tgood = (dec_crc == b);
                dec_crc = 8'hFF;
            end
            3'd3:
            begin
                dec_crc = crc8_step(8'hFF, b);
                dec_hword[15:8] = b;
            end
            3'd4:
            begin
                dec_crc = crc8_step(dec_crc, b);
                dec_hword[7:0] = b;
            end
            default:
            begin
                t = int'(cfg_offset) + int'(scaled(cfg_tspan, dec_tword, cfg_tdiv));
                r.temperature = t[16:0];
                r.humidity = scaled(cfg_hspan, dec_hword, cfg_hdiv);
                r.temp_raw = dec_tword;
                r.hum_raw = dec_hword;
                r.crc_ok = dec_tgood && (dec_crc == b);
                dec_crc = 8'hFF;
                dec_pos = 3'd0;
                return 1'b1;
            end
        endcase
        dec_pos = dec_pos + 3'd1;
        return 1'b0;
    endfunction

    function automatic frame_res_t mk_res(input int temp, input int hum, input logic [15:0] traw,
                                          input logic [15:0] hraw, input logic ok);
        frame_res_t r;
        r = '0;
        r.temperature = temp[16:0];
        r.humidity = hum[14:0];
        r.temp_raw = traw;
        r.hum_raw = hraw;
        r.crc_ok = ok;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [7:0] b, input logic st, input logic typed,
                                        input frame_res_t want);
        dir_row_t d;
        d.rx = b;
        d.start = st;
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    // one byte transfer with random gaps; the predictor runs on acceptance
    task automatic push_byte(input logic [7:0] b, input logic st, input logic typed,
                             input frame_res_t want);
        frame_res_t r;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= st;
        do
            @(posedge clk);
        while (!s_tready);
        if (decode_byte(b, st, r))
            pending_frames.push_back(typed ? want : r);
    endtask

    // hold the sender until every expected frame has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    // register write: setup then access
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TEMP_OFFSET:  cfg_offset = val[15:0];
            REG_TEMP_SPAN:    cfg_tspan = val[14:0];
            REG_TEMP_DIVISOR: cfg_tdiv = val[15:0];
            REG_HUM_SPAN:     cfg_hspan = val[14:0];
            REG_HUM_DIVISOR:  cfg_hdiv = val[15:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] off, input logic [31:0] tspan,
                              input logic [31:0] tdiv, input logic [31:0] hspan,
                              input logic [31:0] hdiv);
        apb_write(REG_TEMP_OFFSET, off);
        apb_write(REG_TEMP_SPAN, tspan);
        apb_write(REG_TEMP_DIVISOR, tdiv);
        apb_write(REG_HUM_SPAN, hspan);
        apb_write(REG_HUM_DIVISOR, hdiv);
    endtask

    // extremes show up often in random words
    function automatic logic [15:0] pick_word();
        int k;
        k = $urandom_range(7);
        if (k == 0)
            return 16'h0000;
        if (k == 1)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // random burst: mostly whole frames, some cut short, some noise
    task automatic send_burst(inout int sent);
        int         kind;
        int         n;
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  tc;
        logic [7:0]  hc;
        logic [7:0]  fb[6];
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            tw = pick_word();
            hw = pick_word();
            tc = word_crc(tw);
            hc = word_crc(hw);
            if ($urandom_range(99) < 15)
                tc = tc ^ 8'($urandom_range(1, 255));
            if ($urandom_range(99) < 15)
                hc = hc ^ 8'($urandom_range(1, 255));
            fb = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
            for (int i = 0; i < 6; i++)
                push_byte(fb[i], (i == 0) && ($urandom_range(99) < 85), 1'b0, '0);
            sent += 6;
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom()), i == 0, 1'b0, '0);
            sent += n;
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom()), 1'($urandom()), 1'b0, '0);
            sent += n;
        end
    endtask

    // compare one result transfer with the oldest expected frame
    task automatic check_frame(input frame_res_t got);
        frame_res_t want;
        if (pending_frames.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected frame: temp %0d hum %0d raw %h/%h crc_ok %b",
                         got.temperature, got.humidity, got.temp_raw, got.hum_raw, got.crc_ok);
        end
        else
        begin
            want = pending_frames.pop_front();
            if (got !== want)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("frame mismatch (exp/act): temp %0d/%0d hum %0d/%0d",
                             want.temperature, got.temperature, want.humidity, got.humidity);
                    $display("  temp_raw %h/%h hum_raw %h/%h crc_ok %b/%b pad %h/%h",
                             want.temp_raw, got.temp_raw, want.hum_raw, got.hum_raw,
                             want.crc_ok, got.crc_ok, want.pad, got.pad);
                end
            end
        end
    endtask

    // result side: check on each transfer, random back-pressure
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_frame(frame_res_t'(m_tdata));
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // stimulus
    initial
    begin
        dir_row_t dir_table[$];
        int       sent;
        bit       paused;

        // zero words with good crcs, at reset scaling
        dir_table.push_back(mk_row(8'h00, 1'b1, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h81, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h81, 1'b0, 1'b1, mk_res(-4500, 0, 16'h0000, 16'h0000, 1'b1)));
        // full-scale words, framed by count with no start mark
        dir_table.push_back(mk_row(8'hFF, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'hFF, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'hAC, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'hFF, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'hFF, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'hAC, 1'b0, 1'b1,
                                   mk_res(13000, 10000, 16'hFFFF, 16'hFFFF, 1'b1)));
        // abandoned response, then a start mark mid-frame
        dir_table.push_back(mk_row(8'h12, 1'b1, 1'b0, '0));
        dir_table.push_back(mk_row(8'h34, 1'b0, 1'b0, '0));
        // good temperature crc, bad humidity crc
        dir_table.push_back(mk_row(8'hBE, 1'b1, 1'b0, '0));
        dir_table.push_back(mk_row(8'hEF, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h92, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_table.push_back(mk_row(8'h00, 1'b0, 1'b1, mk_res(8552, 0, 16'hBEEF, 16'h0000, 1'b0)));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            push_byte(dir_table[i].rx, dir_table[i].start, dir_table[i].typed,
                      dir_table[i].want);

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 35 : (ph < 4) ? 62 : 0;
            recv_idle = (ph < 2) ? 62 : (ph < 4) ? 35 : 0;
            if (ph != 0)
            begin
                // registers change only with the block idle
                drain();
                repeat (80) @(posedge clk);
                case (ph)
                    1: set_config(-32'sd20000, 30000, 1, 30000, 1);
                    2: set_config(20000, 0, 65535, 0, 65535);
                    3: set_config(32'h8000, 32'h7FFF, 0, 32'h7FFF, 0);
                    4: set_config(32'h7FFF, 32'h7FFF, $urandom_range(1, 8), 32'h7FFF,
                                  $urandom_range(1, 8));
                    default: set_config($urandom(), $urandom(), $urandom(), $urandom(),
                                        $urandom());
                endcase
            end
            sent = 0;
            paused = 1'b0;
            while (sent < 140)
            begin
                if (ph == 1 && !paused && sent >= 70)
                begin
                    drain();
                    paused = 1'b1;
                end
                send_burst(sent);
            end
        end

        // let the last frames out, then settle
        drain();
        repeat (100) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
